// File: hdl/swm_pkg.sv
`default_nettype none

package swm_pkg;

  // width and reset value of the window_length register
  localparam int WLEN_BITS  = 7;
  localparam int WLEN_RESET = 64;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load;    // capture sample, read oldest word from the ring
    logic remove;  // drop oldest word from the sorted cells
    logic insert;  // insert new sample, write ring, advance counters
    logic emit;    // load output register from the median cell
  } dp_cmd_t;

  typedef struct packed {
    logic full;       // window holds window_length words
    logic will_fill;  // window is full once the pending insert is done
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/sliding_window_median_core.sv
// A word that slides a full window is accepted, then the oldest word is removed,
// the word inserted and its median emitted onto m_axis; the word that completes
// the window skips the removal. No new sample is accepted until these steps are
// done, a limit set by the single-port ring RAM and the sorted cell row.
// The emit step waits while the previous median is still held on m_axis.
// Reset (rst_ni low, async): window length 64, window empty, no median pending.
`default_nettype none

module sliding_window_median_core #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // configuration: window_length
  input  wire logic                                    cfg_valid_i,
  output      logic                                    cfg_ready_o,
  input  wire logic [swm_pkg::WLEN_BITS-1:0]           cfg_data_i,
  // input stream
  input  wire logic                                    s_axis_tvalid,
  output      logic                                    s_axis_tready,
  input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,  // sample
  // output stream
  output      logic                                    m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  output      logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]  m_axis_tdata   // median
);

  import swm_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  dp_cmd_t                cmd;
  dp_stat_t               stat;
  logic [SAMPLE_BITS-1:0] median;

  assign cfg_ready_o = 1'b1;

  swm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  swm_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .median_o   (median)
  );

  assign m_axis_tdata = TDATA_W'(median);

endmodule

`default_nettype wire

// File: hdl/swm_ram.sv
`default_nettype none

module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  output      logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/swm_ctrl.sv
`default_nettype none

module swm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  input  wire swm_pkg::dp_stat_t stat_i,
  output      swm_pkg::dp_cmd_t  cmd_o
);

  import swm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.full ? S_REMOVE : S_INSERT;
        end
      end
      S_REMOVE: begin
        cmd_o.remove = 1'b1;
        state_d      = S_INSERT;
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = stat_i.will_fill ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_full_goes_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && stat_i.full) |=> (state_q == S_REMOVE))
    else $error("full window did not start a removal");

  a_remove_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REMOVE) |-> ($past(state_q) == S_IDLE && $past(in_valid_i)))
    else $error("removal without an accepted word");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("emitted median not presented");

endmodule

`default_nettype wire

// File: hdl/swm_dp.sv
`default_nettype none

module swm_dp #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [swm_pkg::WLEN_BITS-1:0]      cfg_data_i,
  input  wire logic [SAMPLE_BITS-1:0]             sample_i,
  input  wire swm_pkg::dp_cmd_t                   cmd_i,
  output      swm_pkg::dp_stat_t                  stat_o,
  output      logic [SAMPLE_BITS-1:0]             median_o
);

  import swm_pkg::*;

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W = ((LEN_W > WLEN_BITS) ? LEN_W : WLEN_BITS) + 1;
  localparam int MID   = (WINDOW_MAX - 1) / 2;
  localparam int RST_LEN = (WLEN_RESET > WINDOW_MAX) ? WINDOW_MAX : WLEN_RESET;
  localparam int RST_LO  = MID - (RST_LEN - 1) / 2;

  // clamp the raw register value into 1..WINDOW_MAX
  function automatic logic [LEN_W-1:0] eff_len(input logic [WLEN_BITS-1:0] raw);
    logic [CMP_W-1:0] r;
    r = CMP_W'(raw);
    if (r == '0) begin
      r = CMP_W'(1);
    end else if (r > CMP_W'(WINDOW_MAX)) begin
      r = CMP_W'(WINDOW_MAX);
    end
    return LEN_W'(r);
  endfunction

  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] lo_q, lo_d;     // first sorted cell; median sits at cell MID
  logic [LEN_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;

  logic signed [SAMPLE_BITS-1:0] s_q;
  logic signed [SAMPLE_BITS-1:0] cells_q [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] cells_d [WINDOW_MAX];
  logic        [SAMPLE_BITS-1:0] median_q;
  logic        [SAMPLE_BITS-1:0] ring_rdata;
  logic signed [SAMPLE_BITS-1:0] old_v;

  logic             full;
  logic [LEN_W-1:0] eff_new;
  logic [LEN_W-1:0] span;
  logic [LEN_W-1:0] hi;

  assign full    = (fill_q == len_q);
  assign eff_new = eff_len(cfg_data_i);
  assign old_v   = $signed(ring_rdata);

  // occupied cells are [lo, hi)
  always_comb begin
    if (cmd_i.remove) begin
      span = len_q;
    end else if (full) begin
      span = len_q - LEN_W'(1);
    end else begin
      span = fill_q;
    end
    hi = lo_q + span;
  end

  always_comb begin
    stat_o.full      = full;
    stat_o.will_fill = full || ((fill_q + LEN_W'(1)) == len_q);
  end

  always_comb begin
    len_d  = len_q;
    lo_d   = lo_q;
    fill_d = fill_q;
    ptr_d  = ptr_q;
    if (cfg_we_i) begin
      len_d  = eff_new;
      lo_d   = LEN_W'(MID) - ((eff_new - LEN_W'(1)) >> 1);
      fill_d = '0;
      ptr_d  = '0;
    end else if (cmd_i.insert) begin
      if (!full) begin
        fill_d = fill_q + LEN_W'(1);
      end
      if ((LEN_W'(ptr_q) + LEN_W'(1)) == len_q) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_W'(RST_LEN);
      lo_q   <= LEN_W'(RST_LO);
      fill_q <= '0;
      ptr_q  <= '0;
    end else begin
      len_q  <= len_d;
      lo_q   <= lo_d;
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
    end
  end

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    localparam logic [LEN_W-1:0] POS  = LEN_W'(g);
    localparam logic [LEN_W-1:0] POS1 = LEN_W'(g + 1);
    logic signed [SAMPLE_BITS-1:0] left_v;
    logic signed [SAMPLE_BITS-1:0] right_v;
    logic signed [SAMPLE_BITS-1:0] nxt;

    if (g > 0) begin : g_left
      assign left_v = cells_q[g-1];
    end else begin : g_edge_left
      assign left_v = cells_q[g];
    end
    if (g < WINDOW_MAX - 1) begin : g_right
      assign right_v = cells_q[g+1];
    end else begin : g_edge_right
      assign right_v = cells_q[g];
    end

    always_comb begin
      nxt = cells_q[g];
      if (cmd_i.remove) begin
        // close the gap left by the oldest word
        if (POS >= lo_q && POS1 < hi && cells_q[g] >= old_v) begin
          nxt = right_v;
        end
      end else if (POS >= lo_q && POS <= hi) begin
        // open a slot for the new word
        if (POS < hi && cells_q[g] <= s_q) begin
          nxt = cells_q[g];
        end else if (POS == lo_q || left_v <= s_q) begin
          nxt = s_q;
        end else begin
          nxt = left_v;
        end
      end
    end

    assign cells_d[g] = nxt;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q <= $signed(sample_i);
    end
    if (cmd_i.remove || cmd_i.insert) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        cells_q[i] <= cells_d[i];
      end
    end
    if (cmd_i.emit) begin
      median_q <= cells_q[MID];
    end
  end

  swm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .re_i    (cmd_i.load),
    .addr_i  (ptr_q),
    .wdata_i (s_q),
    .rdata_o (ring_rdata)
  );

  assign median_o = median_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_q)
    else $error("fill count beyond window length");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(ptr_q) < len_q)
    else $error("ring pointer beyond window length");

  a_span_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CMP_W'(lo_q) + CMP_W'(len_q)) <= CMP_W'(WINDOW_MAX))
    && (CMP_W'(lo_q) + CMP_W'((len_q - LEN_W'(1)) >> 1) == CMP_W'(MID)))
    else $error("sorted span misplaced around the median cell");

endmodule

`default_nettype wire
